// ===== hw/rtl/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the cache checker.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LRUKV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRUKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lrukv_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

   // Field widths
   localparam int KEY_W      = 10;
   localparam int DATA_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int CAP_W      = 5;
   localparam int REQ_DATA_W = 80;   // key + value, padded to whole bytes

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request kinds
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   // Control sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_PASS,
      S_DONE
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lrukv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrukv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache.
`default_nettype none

// Key-value cache with least-recently-used replacement. A get (tuser 0) looks up
// the key and returns its data word with status OK, or status MISS. A put
// (tuser 1) updates a present key or inserts a new one, evicting the least
// recent entry once the fill count reaches the capacity register; keys at or
// above KEY_LIMIT get status REJECT. Keys and recency ranks sit in one memory,
// data words in another; valid bits are flip-flops, so the store is empty right
// after reset with no clearing pass. Every item scans the key/rank memory once
// through its single read port; a get hit or an accepted put scans it a second
// time to age the ranks, so hits and accepted puts take longer than misses and
// rejects. Request ready rises again as the result is loaded into the response
// register, which lets a new request be accepted while the previous response
// still waits for rsp_tready.
module lru_key_value_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_LIMIT  = 1000,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [lrukv_pkg::REQ_DATA_W-1:0]    req_tdata,  // key[9:0], value[73:10], pad
   input  wire logic                                req_tuser,  // req_type
   // response channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [lrukv_pkg::DATA_W-1:0]        rsp_tdata,  // read_value[63:0]
   output      logic [lrukv_pkg::STATUS_W-1:0]      rsp_tuser,  // status[1:0]
   // capacity register
   input  wire logic                                csr_wen,
   input  wire logic [lrukv_pkg::CAP_W-1:0]         csr_wdata
);

   import lrukv_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KR_W   = KEY_W + RANK_W;
   localparam int LIM_W  = KEY_W + 1;

   // Sequencer
   fsm_state_type state_ff, state_in;

   // Scan counter and check stage
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;

   // Request under work
   logic                  put_ff, put_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   // Scan results
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]     hit_rank_ff, hit_rank_in;
   logic                  old_vld_ff, old_vld_in;
   logic [IDX_W-1:0]      old_idx_ff, old_idx_in;
   logic [RANK_W-1:0]     old_rank_ff, old_rank_in;
   logic                  free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;

   // Rank update pass control
   logic [IDX_W-1:0]      tgt_ff, tgt_in;
   logic [CNT_W-1:0]      thr_ff, thr_in;

   // Result under construction
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rdv_ff, rdv_in;

   // Store bookkeeping and configuration
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;

   // Response register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   // Memory ports
   logic                  kr_we, kr_re;
   logic [IDX_W-1:0]      kr_waddr, kr_raddr;
   logic [KR_W-1:0]       kr_wdata, kr_rdata;
   logic                  dt_we, dt_re;
   logic [IDX_W-1:0]      dt_waddr, dt_raddr;
   logic [VALUE_BITS-1:0] dt_rdata;

   // Decode helpers
   logic                  req_fire, rsp_free, cnt_last;
   logic [KEY_W-1:0]      chk_key;
   logic [RANK_W-1:0]     chk_rank;
   logic                  chk_valid;
   logic                  reject, go_pass, evict;
   logic [CMP_W-1:0]      cap_ext, eff_cap;
   logic [IDX_W-1:0]      ins_idx;

   // Key/rank memory: {rank, key} per entry
   lrukv_ram #(.WIDTH(KR_W), .DEPTH(ENTRIES)) u_kr_ram (
      .clock   (clock),
      .wr_en   (kr_we),
      .wr_addr (kr_waddr),
      .wr_data (kr_wdata),
      .rd_en   (kr_re),
      .rd_addr (kr_raddr),
      .rd_data (kr_rdata)
   );

   // Data word memory
   lrukv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_dt_ram (
      .clock   (clock),
      .wr_en   (dt_we),
      .wr_addr (dt_waddr),
      .wr_data (val_ff),
      .rd_en   (dt_re),
      .rd_addr (dt_raddr),
      .rd_data (dt_rdata)
   );

   // Handshake and decode
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign cnt_last   = (cnt_ff == CNT_W'(ENTRIES));
   assign chk_key    = kr_rdata[KEY_W-1:0];
   assign chk_rank   = kr_rdata[KEY_W +: RANK_W];
   assign chk_valid  = valid_ff[chk_idx_ff];
   assign reject     = put_ff && ({1'b0, key_ff} >= LIM_W'(KEY_LIMIT));
   assign go_pass    = put_ff ? !reject : hit_ff;

   // Effective capacity: zero reads as one, saturates at ENTRIES
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict = (CMP_W'(fill_ff) >= eff_cap);

   // Insert slot: lowest free entry, counting the victim as freed
   assign ins_idx = (free_vld_ff && (!evict || (free_idx_ff < old_idx_ff))) ?
                    free_idx_ff : old_idx_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = go_pass ? S_PASS : S_DONE;
         end
         S_PASS: begin
            if (cnt_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      put_in        = put_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      old_vld_in    = old_vld_ff;
      old_idx_in    = old_idx_ff;
      old_rank_in   = old_rank_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      tgt_in        = tgt_ff;
      thr_in        = thr_ff;
      status_in     = status_ff;
      rdv_in        = rdv_ff;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      cap_in        = csr_wen ? csr_wdata : cap_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      kr_we         = 1'b0;
      kr_waddr      = chk_idx_ff;
      kr_wdata      = kr_rdata;
      kr_re         = 1'b0;
      kr_raddr      = cnt_ff[IDX_W-1:0];
      dt_we         = 1'b0;
      dt_waddr      = hit_idx_ff;
      dt_re         = 1'b0;
      dt_raddr      = hit_idx_ff;

      unique case (state_ff)
         // Take a word and clear the scan results
         S_IDLE: begin
            if (req_fire) begin
               put_in      = (req_tuser == REQ_PUT);
               key_in      = req_tdata[KEY_W-1:0];
               val_in      = req_tdata[KEY_W +: VALUE_BITS];
               cnt_in      = '0;
               hit_in      = 1'b0;
               old_vld_in  = 1'b0;
               free_vld_in = 1'b0;
            end
         end

         // Read each entry; the check stage works on the read of the cycle before
         S_SCAN: begin
            kr_re      = !cnt_last;
            chk_vld_in = !cnt_last;
            chk_idx_in = cnt_ff[IDX_W-1:0];
            cnt_in     = cnt_last ? '0 : cnt_ff + CNT_W'(1);
            if (chk_vld_ff) begin
               if (chk_valid) begin
                  if (!hit_ff && (chk_key == key_ff)) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = chk_idx_ff;
                     hit_rank_in = chk_rank;
                  end
                  if (!old_vld_ff || (chk_rank > old_rank_ff)) begin
                     old_vld_in  = 1'b1;
                     old_idx_in  = chk_idx_ff;
                     old_rank_in = chk_rank;
                  end
               end else if (!free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
         end

         // Pick the action; write data, fetch hit data, adjust valid bits
         S_DECIDE: begin
            status_in = STATUS_OK;
            rdv_in    = 1'b0;
            tgt_in    = hit_idx_ff;
            thr_in    = CNT_W'(hit_rank_ff);
            if (!put_ff) begin
               if (hit_ff) begin
                  dt_re  = 1'b1;
                  rdv_in = 1'b1;
               end else begin
                  status_in = STATUS_MISS;
               end
            end else if (reject) begin
               status_in = STATUS_REJECT;
            end else if (hit_ff) begin
               dt_we = 1'b1;
            end else begin
               if (evict) begin
                  valid_in[old_idx_ff] = 1'b0;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               valid_in[ins_idx] = 1'b1;
               dt_we    = 1'b1;
               dt_waddr = ins_idx;
               tgt_in   = ins_idx;
               thr_in   = CNT_W'(ENTRIES);
            end
         end

         // Age ranks below the threshold; target becomes most recent
         S_PASS: begin
            kr_re      = !cnt_last;
            chk_vld_in = !cnt_last;
            chk_idx_in = cnt_ff[IDX_W-1:0];
            cnt_in     = cnt_last ? '0 : cnt_ff + CNT_W'(1);
            if (chk_vld_ff) begin
               if (chk_idx_ff == tgt_ff) begin
                  kr_we    = 1'b1;
                  kr_wdata = {RANK_W'(0), key_ff};
               end else if (chk_valid && (CNT_W'(chk_rank) < thr_ff)) begin
                  kr_we    = 1'b1;
                  kr_wdata = {chk_rank + RANK_W'(1), chk_key};
               end
            end
         end

         // Load the response register once it is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status_ff;
               rsp_tdata_in  = rdv_ff ? DATA_W'(dt_rdata) : '0;
            end
         end

         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         fill_ff       <= '0;
         cap_ff        <= CAP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         valid_ff      <= valid_in;
         fill_ff       <= fill_in;
         cap_ff        <= cap_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff   <= chk_idx_in;
      put_ff       <= put_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      old_vld_ff   <= old_vld_in;
      old_idx_ff   <= old_idx_in;
      old_rank_ff  <= old_rank_in;
      free_vld_ff  <= free_vld_in;
      free_idx_ff  <= free_idx_in;
      tgt_ff       <= tgt_in;
      thr_ff       <= thr_in;
      status_ff    <= status_in;
      rdv_ff       <= rdv_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lrukv_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lrukv_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [lrukv_pkg::DATA_W-1:0]   rsp_tdata,
   input wire logic [lrukv_pkg::STATUS_W-1:0] rsp_tuser
);

   import lrukv_pkg::*;

   // A stalled response word holds
   `LRUKV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // One request in flight: ready drops right after an accept
   `LRUKV_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")

   // Only defined status codes leave the block
   `LRUKV_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser == STATUS_OK || rsp_tuser == STATUS_MISS || rsp_tuser == STATUS_REJECT, "undefined status code")

   // Miss and reject carry a zero data word
   `LRUKV_ASSERT_IMPLY(a_zero_data, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata == '0, "nonzero data on miss or reject")

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
